### rtl/core/xdp_pkg.sv
// Shared types, character codes and pattern tables of the doctype pre-scanner.
`timescale 1ns / 1ps

package xdp_pkg;

  // Width of the match offset on the result port
  localparam int unsigned OUT_W = 24;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte codes the scanner cares about
  localparam logic [7:0] CHR_LT     = 8'h3C;  // <
  localparam logic [7:0] CHR_BANG   = 8'h21;  // !
  localparam logic [7:0] CHR_QUEST  = 8'h3F;  // ?
  localparam logic [7:0] CHR_DASH   = 8'h2D;  // -
  localparam logic [7:0] CHR_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CHR_RBRACK = 8'h5D;  // ]
  localparam logic [7:0] CHR_GT     = 8'h3E;  // >
  localparam logic [7:0] CHR_A      = 8'h41;
  localparam logic [7:0] CHR_C      = 8'h43;
  localparam logic [7:0] CHR_D      = 8'h44;
  localparam logic [7:0] CHR_E      = 8'h45;
  localparam logic [7:0] CHR_O      = 8'h4F;
  localparam logic [7:0] CHR_P      = 8'h50;
  localparam logic [7:0] CHR_T      = 8'h54;
  localparam logic [7:0] CHR_Y      = 8'h59;

  // Byte class: every byte that appears in an opener or terminator, else other
  typedef enum logic [3:0] {
    CL_OTHER,
    CL_LT,
    CL_BANG,
    CL_QUEST,
    CL_DASH,
    CL_LBRACK,
    CL_RBRACK,
    CL_GT,
    CL_A,
    CL_C,
    CL_D,
    CL_E,
    CL_O,
    CL_P,
    CL_T,
    CL_Y
  } xdp_class_e;

  // Scanner mode
  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_OPEN_COMMENT,
    MODE_OPEN_CDATA,
    MODE_OPEN_DOCTYPE,
    MODE_IN_COMMENT,
    MODE_IN_CDATA,
    MODE_IN_PI,
    MODE_DONE
  } xdp_mode_e;

  // Queue word tag: classified byte plus end-of-document flag
  typedef struct packed {
    xdp_class_e cls;
    logic       last;
  } xdp_tag_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic pop;
    logic emit;
    logic found;
    logic last;
  } xdp_stat_t;

  // Map a raw byte to its class
  function automatic xdp_class_e classify(input logic [7:0] b);
    xdp_class_e c;
    unique case (b)
      CHR_LT:     c = CL_LT;
      CHR_BANG:   c = CL_BANG;
      CHR_QUEST:  c = CL_QUEST;
      CHR_DASH:   c = CL_DASH;
      CHR_LBRACK: c = CL_LBRACK;
      CHR_RBRACK: c = CL_RBRACK;
      CHR_GT:     c = CL_GT;
      CHR_A:      c = CL_A;
      CHR_C:      c = CL_C;
      CHR_D:      c = CL_D;
      CHR_E:      c = CL_E;
      CHR_O:      c = CL_O;
      CHR_P:      c = CL_P;
      CHR_T:      c = CL_T;
      CHR_Y:      c = CL_Y;
      default:    c = CL_OTHER;
    endcase
    return c;
  endfunction

  // Expected class at opener position idx (positions 3 and up)
  function automatic xdp_class_e open_pat(input xdp_mode_e m, input logic [3:0] idx);
    xdp_class_e c;
    c = CL_OTHER;
    unique case (m)
      MODE_OPEN_COMMENT: begin
        if (idx == 4'd3) c = CL_DASH;
      end
      MODE_OPEN_CDATA: begin
        unique case (idx)
          4'd3:    c = CL_C;
          4'd4:    c = CL_D;
          4'd5:    c = CL_A;
          4'd6:    c = CL_T;
          4'd7:    c = CL_A;
          4'd8:    c = CL_LBRACK;
          default: c = CL_OTHER;
        endcase
      end
      MODE_OPEN_DOCTYPE: begin
        unique case (idx)
          4'd3:    c = CL_O;
          4'd4:    c = CL_C;
          4'd5:    c = CL_T;
          4'd6:    c = CL_Y;
          4'd7:    c = CL_P;
          4'd8:    c = CL_E;
          default: c = CL_OTHER;
        endcase
      end
      default: c = CL_OTHER;
    endcase
    return c;
  endfunction

  // Full opener length
  function automatic logic [3:0] open_len(input xdp_mode_e m);
    logic [3:0] n;
    unique case (m)
      MODE_OPEN_COMMENT: n = 4'd4;
      MODE_OPEN_CDATA:   n = 4'd9;
      MODE_OPEN_DOCTYPE: n = 4'd9;
      default:           n = 4'd0;
    endcase
    return n;
  endfunction

  // Expected class at terminator position idx
  function automatic xdp_class_e term_pat(input xdp_mode_e m, input logic [1:0] idx);
    xdp_class_e c;
    unique case (m)
      MODE_IN_COMMENT: c = (idx == 2'd2) ? CL_GT : CL_DASH;
      MODE_IN_CDATA:   c = (idx == 2'd2) ? CL_GT : CL_RBRACK;
      MODE_IN_PI:      c = (idx == 2'd0) ? CL_QUEST : CL_GT;
      default:         c = CL_OTHER;
    endcase
    return c;
  endfunction

  // Terminator length
  function automatic logic [1:0] term_len(input xdp_mode_e m);
    logic [1:0] n;
    unique case (m)
      MODE_IN_COMMENT: n = 2'd3;
      MODE_IN_CDATA:   n = 2'd3;
      MODE_IN_PI:      n = 2'd2;
      default:         n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/xdp_front.sv
// Front end: accepts bytes, classifies them and tags each with its document offset.
`timescale 1ns / 1ps

module xdp_front
  import xdp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output xdp_tag_t               q_tag_o,
  output logic [OFFSET_BITS-1:0] q_pos_o
);

  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  // Input side stalls only on a full queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  assign q_tag_o.cls  = classify(data_byte_i);
  assign q_tag_o.last = last_byte_i;
  assign q_pos_o      = pos_q;

  // Offset counter, back to zero after the last byte of a document
  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      pos_d = last_byte_i ? '0 : pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

### rtl/core/xdp_queue.sv
// Short word queue between the front and back ends.
`timescale 1ns / 1ps

module xdp_queue
  import xdp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  xdp_tag_t               push_tag_i,
  input  logic [OFFSET_BITS-1:0] push_pos_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output xdp_tag_t               head_tag_o,
  output logic [OFFSET_BITS-1:0] head_pos_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  xdp_tag_t               tag_q [QUEUE_DEPTH];
  logic [OFFSET_BITS-1:0] pos_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);
  assign head_tag_o = tag_q[rd_q];
  assign head_pos_o = pos_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      tag_q[wr_q] <= push_tag_i;
      pos_q[wr_q] <= push_pos_i;
    end
  end

endmodule

### rtl/core/xdp_back.sv
// Back end: opener/terminator state machine and the result register.
`timescale 1ns / 1ps

module xdp_back
  import xdp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  xdp_tag_t               q_tag_i,
  input  logic [OFFSET_BITS-1:0] q_pos_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   doctype_found_o,
  output logic [OUT_W-1:0]       match_offset_o,
  output xdp_stat_t              stat_o
);

  xdp_mode_e              mode_q, mode_d;
  logic [3:0]             op_q, op_d, op_inc;
  logic [1:0]             tp_q, tp_d, tp_inc;
  logic [OFFSET_BITS-1:0] cand_q, cand_d;
  logic                   hit, do_restart, emit;
  logic [OFFSET_BITS-1:0] res_offset;

  logic                         out_valid_q, out_valid_d;
  logic                         found_q;
  logic [OFFSET_BITS-1:0]       offset_q;
  logic [OFFSET_BITS+OUT_W-1:0] offset_ext;

  xdp_class_e cls;

  assign cls    = q_tag_i.cls;
  assign op_inc = op_q + 4'd1;
  assign tp_inc = tp_q + 2'd1;

  // Take a word whenever the result slot is free or draining
  assign q_pop_o = ~q_empty_i & (~out_valid_q | ~out_stall_i);

  // Next state
  always_comb begin
    mode_d     = mode_q;
    op_d       = op_q;
    tp_d       = tp_q;
    cand_d     = cand_q;
    hit        = 1'b0;
    do_restart = 1'b0;
    if (q_pop_o) begin
      unique case (mode_q)
        MODE_NORMAL: begin
          if (op_q == 4'd0) begin
            if (cls == CL_LT) begin
              cand_d = q_pos_i;
              op_d   = 4'd1;
            end
          end else if (op_q == 4'd1) begin
            if (cls == CL_BANG) begin
              op_d = 4'd2;
            end else if (cls == CL_QUEST) begin
              mode_d = MODE_IN_PI;
              op_d   = 4'd0;
              tp_d   = 2'd0;
            end else begin
              do_restart = 1'b1;
            end
          end else begin
            // third byte picks one of the three "<!" openers
            unique case (cls)
              CL_DASH: begin
                mode_d = MODE_OPEN_COMMENT;
                op_d   = 4'd3;
              end
              CL_LBRACK: begin
                mode_d = MODE_OPEN_CDATA;
                op_d   = 4'd3;
              end
              CL_D: begin
                mode_d = MODE_OPEN_DOCTYPE;
                op_d   = 4'd3;
              end
              default: do_restart = 1'b1;
            endcase
          end
        end
        MODE_OPEN_COMMENT, MODE_OPEN_CDATA, MODE_OPEN_DOCTYPE: begin
          if (op_q >= open_len(mode_q) || cls != open_pat(mode_q, op_q)) begin
            do_restart = 1'b1;
          end else begin
            op_d = op_inc;
            if (op_inc == open_len(mode_q)) begin
              op_d = 4'd0;
              tp_d = 2'd0;
              unique case (mode_q)
                MODE_OPEN_COMMENT: mode_d = MODE_IN_COMMENT;
                MODE_OPEN_CDATA:   mode_d = MODE_IN_CDATA;
                default: begin
                  mode_d = MODE_DONE;
                  hit    = 1'b1;
                end
              endcase
            end
          end
        end
        MODE_IN_COMMENT, MODE_IN_CDATA, MODE_IN_PI: begin
          if (cls == term_pat(mode_q, tp_q)) begin
            tp_d = tp_inc;
            if (tp_inc == term_len(mode_q)) begin
              mode_d = MODE_NORMAL;
              op_d   = 4'd0;
              tp_d   = 2'd0;
            end
          end else if (cls != term_pat(mode_q, 2'd0)) begin
            // a repeated first terminator byte keeps the progress
            tp_d = 2'd0;
          end
        end
        default: ;
      endcase

      // failed opener: a '<' starts the next candidate
      if (do_restart) begin
        mode_d = MODE_NORMAL;
        tp_d   = 2'd0;
        if (cls == CL_LT) begin
          cand_d = q_pos_i;
          op_d   = 4'd1;
        end else begin
          op_d = 4'd0;
        end
      end

      // end of document: back to the reset state
      if (q_tag_i.last) begin
        mode_d = MODE_NORMAL;
        op_d   = 4'd0;
        tp_d   = 2'd0;
        cand_d = '0;
      end
    end
  end

  // Result of the current word
  always_comb begin
    emit       = q_pop_o & (hit | (mode_q != MODE_DONE && q_tag_i.last));
    res_offset = hit ? cand_q : q_pos_i + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      op_q   <= 4'd0;
      tp_q   <= 2'd0;
      cand_q <= '0;
    end else begin
      mode_q <= mode_d;
      op_q   <= op_d;
      tp_q   <= tp_d;
      cand_q <= cand_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q  <= hit;
      offset_q <= res_offset;
    end
  end

  assign offset_ext      = {{OUT_W{1'b0}}, offset_q};
  assign out_valid_o     = out_valid_q;
  assign doctype_found_o = found_q;
  assign match_offset_o  = offset_ext[OUT_W-1:0];

  assign stat_o.pop   = q_pop_o;
  assign stat_o.emit  = emit;
  assign stat_o.found = hit;
  assign stat_o.last  = q_tag_i.last;

endmodule

### rtl/core/xml_doctype_prescanner.sv
// Top level of the streaming doctype pre-scanner.
//
//   channel  dir  handshake               word
//   in       in   in_valid_i/in_stall_o   data_byte_i, last_byte_i
//   out      out  out_valid_o/out_stall_i doctype_found_o, match_offset_o
//
// One byte per cycle sustained while the output is not stalled; a byte that is
// taken is written into the queue, then scanned, and its result is loaded into
// the result register when the scanner takes it from the queue.
// The queue holds two words; in_stall_o rises only when it is full.
// Results are held in a single output register; a stalled result blocks
// the scanner, which then fills the queue.
// Reset clears the offset counter, the queue and the scanner; no clear pass.
`timescale 1ns / 1ps

module xml_doctype_prescanner
  import xdp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             doctype_found_o,
  output logic [OUT_W-1:0] match_offset_o
);

  logic                   q_full, q_empty, q_push, q_pop;
  xdp_tag_t               push_tag, head_tag;
  logic [OFFSET_BITS-1:0] push_pos, head_pos;
  xdp_stat_t              stat;

  xdp_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_tag_o    (push_tag),
    .q_pos_o    (push_pos)
  );

  xdp_queue #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_tag_i(push_tag),
    .push_pos_i(push_pos),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_tag_o(head_tag),
    .head_pos_o(head_pos)
  );

  xdp_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_tag_i        (head_tag),
    .q_pos_i        (head_pos),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .doctype_found_o(doctype_found_o),
    .match_offset_o (match_offset_o),
    .stat_o         (stat)
  );

`ifndef SYNTHESIS
  // A not-found result only ever comes from the last byte of a document
  a_notfound_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.emit && !stat.found |-> stat.last)
    else $error("not-found result on a byte that is not the last");

  // The scanner never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |-> !(out_valid_o && out_stall_i))
    else $error("word taken while result is stalled");

  // A new result is visible on the next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.emit |=> out_valid_o && doctype_found_o == $past(stat.found))
    else $error("result register did not load");

  // Nothing leaves an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

### sim/tb_xml_doctype_prescanner.sv
// Self-checking testbench of the streaming doctype pre-scanner.
`timescale 1ns / 1ps

module tb_xml_doctype_prescanner;
  import xdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RAND_BYTES  = 1950;
  localparam int unsigned DIR_ROWS    = 10;

  // One expected result word
  typedef struct {
    bit               found;
    logic [OUT_W-1:0] offset;
  } doc_result_t;

  // One directed document; typed rows carry their result
  typedef struct {
    string            text;
    bit               typed;
    bit               found;
    logic [OUT_W-1:0] offset;
  } doc_case_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i     = 8'h00;
  logic             last_byte_i     = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i     = 1'b0;
  logic             doctype_found_o;
  logic [OUT_W-1:0] match_offset_o;

  // Table row of the word on the bus, -1 for random documents
  int               word_row        = -1;

  doc_case_t dir_tbl [DIR_ROWS] = '{
    '{"\377",                    1'b1, 1'b0, 24'd1},
    '{"<!DOCTYPE",               1'b1, 1'b1, 24'd0},
    '{"<<!DOCTYPE x",            1'b1, 1'b1, 24'd1},
    '{"<!--<!DOCTYPE-->",        1'b1, 1'b0, 24'd16},
    '{"<!doctype",               1'b1, 1'b0, 24'd9},
    '{"<!DOCTYP",                1'b1, 1'b0, 24'd8},
    '{"<?pi",                    1'b1, 1'b0, 24'd4},
    '{"<![CDATA[]]]>x<!DOCTYPE", 1'b0, 1'b0, 24'd0},
    '{"<?x?><!DOCTYPE",          1'b0, 1'b0, 24'd0},
    '{"<!x<!-a<![C<!DOCTYPE",    1'b0, 1'b0, 24'd0}
  };

  doc_result_t      doc_result_q[$];
  logic [7:0]       doc_buf[$];
  int               errors   = 0;
  int               sent_cnt = 0;
  int               cyc_cnt  = 0;

  // Scanner state mirror
  xdp_mode_e        scn_mode = MODE_NORMAL;
  int               opn_cnt  = 0;
  int               trm_cnt  = 0;
  logic [OUT_W-1:0] byte_pos = '0;
  logic [OUT_W-1:0] cand_pos = '0;

  xml_doctype_prescanner u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .doctype_found_o(doctype_found_o),
    .match_offset_o (match_offset_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scanner prediction
  // ---------------------------------------------------------------------------

  function automatic string opener_text(input xdp_mode_e m);
    if (m == MODE_OPEN_COMMENT) return "<!--";
    if (m == MODE_OPEN_CDATA) return "<![CDATA[";
    return "<!DOCTYPE";
  endfunction

  function automatic string closer_text(input xdp_mode_e m);
    if (m == MODE_IN_COMMENT) return "-->";
    if (m == MODE_IN_CDATA) return "]]>";
    return "?>";
  endfunction

  task automatic clear_scanner();
    scn_mode = MODE_NORMAL;
    opn_cnt  = 0;
    trm_cnt  = 0;
    byte_pos = '0;
    cand_pos = '0;
  endtask

  // Failed opener: back to normal, a '<' starts a fresh candidate
  task automatic drop_candidate(input logic [7:0] b);
    scn_mode = MODE_NORMAL;
    trm_cnt  = 0;
    if (b == CHR_LT) begin
      cand_pos = byte_pos;
      opn_cnt  = 1;
    end else begin
      opn_cnt = 0;
    end
  endtask

  task automatic enter_skip(input xdp_mode_e m);
    scn_mode = m;
    opn_cnt  = 0;
    trm_cnt  = 0;
  endtask

  // Advance the scanner by one byte; hit is set when the doctype opener completes
  task automatic scan_doc_byte(input logic [7:0] b, output bit hit);
    string pat;
    hit = 1'b0;
    case (scn_mode)
      MODE_NORMAL: begin
        if (opn_cnt == 0) begin
          if (b == CHR_LT) begin
            cand_pos = byte_pos;
            opn_cnt  = 1;
          end
        end else if (opn_cnt == 1) begin
          if (b == CHR_BANG) opn_cnt = 2;
          else if (b == CHR_QUEST) enter_skip(MODE_IN_PI);
          else drop_candidate(b);
        end else begin
          if (b == CHR_DASH) begin
            scn_mode = MODE_OPEN_COMMENT;
            opn_cnt  = 3;
          end else if (b == CHR_LBRACK) begin
            scn_mode = MODE_OPEN_CDATA;
            opn_cnt  = 3;
          end else if (b == CHR_D) begin
            scn_mode = MODE_OPEN_DOCTYPE;
            opn_cnt  = 3;
          end else begin
            drop_candidate(b);
          end
        end
      end
      MODE_OPEN_COMMENT, MODE_OPEN_CDATA, MODE_OPEN_DOCTYPE: begin
        pat = opener_text(scn_mode);
        if (opn_cnt >= pat.len() || b != pat[opn_cnt]) begin
          drop_candidate(b);
        end else begin
          opn_cnt++;
          if (opn_cnt == pat.len()) begin
            if (scn_mode == MODE_OPEN_DOCTYPE) begin
              scn_mode = MODE_DONE;
              opn_cnt  = 0;
              hit      = 1'b1;
            end else if (scn_mode == MODE_OPEN_COMMENT) begin
              enter_skip(MODE_IN_COMMENT);
            end else begin
              enter_skip(MODE_IN_CDATA);
            end
          end
        end
      end
      MODE_IN_COMMENT, MODE_IN_CDATA, MODE_IN_PI: begin
        pat = closer_text(scn_mode);
        if (trm_cnt >= pat.len()) trm_cnt = 0;
        if (b == pat[trm_cnt]) begin
          trm_cnt++;
          if (trm_cnt == pat.len()) enter_skip(MODE_NORMAL);
        end else if (b != pat[0]) begin
          // repeated first terminator byte keeps the progress
          trm_cnt = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Predict the result of one accepted word and queue it
  task automatic predict_word(input logic [7:0] b, input bit is_last, input int row);
    bit          hit;
    bit          emit;
    doc_result_t r;
    emit = 1'b0;
    if (scn_mode != MODE_DONE) begin
      scan_doc_byte(b, hit);
      if (hit) begin
        r.found  = 1'b1;
        r.offset = cand_pos;
        emit     = 1'b1;
      end else if (is_last) begin
        r.found  = 1'b0;
        r.offset = byte_pos + 1'b1;
        emit     = 1'b1;
      end
    end
    if (emit) begin
      if (row >= 0 && dir_tbl[row].typed) begin
        r.found  = dir_tbl[row].found;
        r.offset = dir_tbl[row].offset;
      end
      doc_result_q.push_back(r);
    end
    if (is_last) clear_scanner();
    else byte_pos = byte_pos + 1'b1;
  endtask

  // Input acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predict_word(data_byte_i, last_byte_i, word_row);
  end

  // Result checking
  always @(posedge clk_i) begin
    doc_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (doc_result_q.size() == 0) begin
        $display("%0t: unexpected result found=%0b offset=%0d", $time, doctype_found_o,
                 match_offset_o);
        errors++;
      end else begin
        e = doc_result_q.pop_front();
        if (doctype_found_o !== e.found) begin
          $display("%0t: doctype_found expected %0b got %0b", $time, e.found, doctype_found_o);
          errors++;
        end
        if (match_offset_o !== e.offset) begin
          $display("%0t: match_offset expected %0d got %0d", $time, e.offset, match_offset_o);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("[xml_doctype_prescanner] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, periodic long hold-off, one quiet stretch
  // ---------------------------------------------------------------------------

  initial begin
    int rx_cyc;
    int hold_left;
    rx_cyc    = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_cyc % 1000 == 400) begin
        hold_left = 60;
        out_stall_i <= 1'b1;
      end else if (rx_cyc >= 1500 && rx_cyc < 2200) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 18);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  task automatic send_word(input logic [7:0] b, input bit is_last, input int row);
    if (!(sent_cnt >= 600 && sent_cnt < 900)) begin
      while ($urandom_range(0, 99) < 18) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    word_row    <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (doc_result_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_char();
    string hot_chars;
    hot_chars = "<!-[]>?DOCTYPEA";
    if ($urandom_range(0, 1) == 1) return hot_chars[$urandom_range(0, hot_chars.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_text(input int n);
    repeat (n) doc_buf.push_back(rand_char());
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
  endtask

  // Random document built from text, skipped sections, openers and broken openers
  task automatic build_doc();
    int    n_frag;
    int    kind;
    string op;
    string cl;
    doc_buf.delete();
    n_frag = $urandom_range(1, 5);
    repeat (n_frag) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_text($urandom_range(1, 8));
      end else if (kind < 70) begin
        case ($urandom_range(0, 2))
          0: begin op = "<!--"; cl = "-->"; end
          1: begin op = "<![CDATA["; cl = "]]>"; end
          default: begin op = "<?"; cl = "?>"; end
        endcase
        add_str(op);
        add_text($urandom_range(0, 6));
        // now and then leave the section open
        if ($urandom_range(0, 9) != 0) add_str(cl);
      end else if (kind < 85) begin
        add_str("<!DOCTYPE");
        add_text($urandom_range(0, 4));
      end else begin
        case ($urandom_range(0, 2))
          0: op = "<!DOCTYPE";
          1: op = "<![CDATA[";
          default: op = "<!--";
        endcase
        add_str(op.substr(0, $urandom_range(0, op.len() - 2)));
        add_text(1);
      end
    end
  endtask

  initial begin
    string txt;
    bit    paused;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed documents
    for (int r = 0; r < DIR_ROWS; r++) begin
      txt = dir_tbl[r].text;
      for (int i = 0; i < txt.len(); i++) send_word(txt[i], i == txt.len() - 1, r);
    end

    // Random documents
    while (sent_cnt < RAND_BYTES) begin
      build_doc();
      if (!paused && sent_cnt >= 1200) begin
        wait_drained();
        paused = 1'b1;
      end
      for (int i = 0; i < doc_buf.size(); i++) send_word(doc_buf[i], i == doc_buf.size() - 1, -1);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (doc_result_q.size() != 0) begin
      $display("%0t: %0d results still expected", $time, doc_result_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[xml_doctype_prescanner] OK");
    end else begin
      $display("[xml_doctype_prescanner] ERROR");
    end
    $finish;
  end

endmodule
